// ===== hdl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes of the sorted record table
// Record layout, request and status codes, cell operations and the controller states.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam logic [2:0] REQ_INSERT   = 3'd0;
  localparam logic [2:0] REQ_FIND     = 3'd1;
  localparam logic [2:0] REQ_DEL_CODE = 3'd2;
  localparam logic [2:0] REQ_DEL_EXP  = 3'd3;
  localparam logic [2:0] REQ_LIST_OK  = 3'd4;
  localparam logic [2:0] REQ_LIST_EXP = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] code;
    logic [23:0]        price;
    logic [15:0]        quantity;
    date_t              expiry;
  } rec_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_CMP
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_FIN,
    S_CMP
  } state_t;

endpackage

// ===== hdl/srt_if.sv =====
// ----------------------------------------------------------------------------
// srt_req_if / srt_res_if: request and result channels
// Valid and ready handshake; a word moves when both are high.
// ----------------------------------------------------------------------------
interface srt_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] code;
  logic [23:0]        price;
  logic [15:0]        quantity;
  logic [4:0]         date_day;
  logic [3:0]         date_month;
  logic [13:0]        date_year;
  modport source (output valid, req_type, code, price, quantity, date_day, date_month,
                  date_year, input ready);
  modport sink (input valid, req_type, code, price, quantity, date_day, date_month,
                date_year, output ready);
endinterface

interface srt_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] rec_code;
  logic [23:0]        rec_price;
  logic [15:0]        rec_quantity;
  logic [4:0]         rec_day;
  logic [3:0]         rec_month;
  logic [13:0]        rec_year;
  logic [4:0]         removed_count;
  logic               last;
  modport source (output valid, status, rec_code, rec_price, rec_quantity, rec_day,
                  rec_month, rec_year, removed_count, last, input ready);
  modport sink (input valid, status, rec_code, rec_price, rec_quantity, rec_day,
                rec_month, rec_year, removed_count, last, output ready);
endinterface

// ===== hdl/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell: one slot of the record chain
// Holds one record; rotates, opens a gap for an insert or closes a hole.
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic             clk,
  input  logic             rst,
  input  srt_pkg::cell_op_t op,
  input  srt_pkg::rec_t    left,
  input  srt_pkg::rec_t    right,
  input  srt_pkg::rec_t    new_rec,
  input  logic             gt_left,
  input  logic             hole_left,
  output srt_pkg::rec_t    rec,
  output logic             gt,
  output logic             hole
);
  import srt_pkg::*;

  rec_t rec_next;

  assign gt   = !rec.valid || (rec.price > new_rec.price);
  assign hole = !rec.valid || hole_left;

  always_comb begin
    rec_next = rec;
    case (op)
      CELL_ROT: rec_next = right;
      CELL_INS: begin
        if (gt_left) rec_next = left;
        else if (gt) rec_next = new_rec;
      end
      CELL_CMP: begin
        if (hole) rec_next = right;
      end
      default: rec_next = rec;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec.valid <= rec_next.valid;
    end
    rec.code     <= rec_next.code;
    rec.price    <= rec_next.price;
    rec.quantity <= rec_next.quantity;
    rec.expiry   <= rec_next.expiry;
  end
endmodule

// ===== hdl/sorted_record_table_with_expiry_core.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table_with_expiry_core: price-ordered record table
// A chain of record cells with a head controller for search, listing and delete.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  req     | in  | one request
//  res     | out | one result, or one per listed record with last on the final
//
//  Insert: the cells compare prices in parallel and shift once.
//  Find and listings rotate the whole chain past the head.
//  Deletes add a hole-closing pass over the chain after the result is loaded.
//  Reset clears the valid bits and the fill count.
//  A stalled result holds a listing's rotation; requests are taken only when idle.
module sorted_record_table_with_expiry_core #(
  parameter int TABLE_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  srt_req_if.sink   req,
  srt_res_if.source res
);
  import srt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;
  cell_op_t op;
  rec_t cell_q [TABLE_DEPTH];
  logic gt [TABLE_DEPTH];
  logic hole [TABLE_DEPTH];
  rec_t tail_in, new_rec, wrap;

  logic [2:0] rq;
  logic signed [31:0] rq_code;
  date_t rq_date;
  logic [CW-1:0] fill, step;
  logic found;
  rec_t held;
  logic [4:0] removed;
  logic [1:0] ins_status;

  logic ov;
  logic [1:0] o_status;
  rec_t o_rec;
  logic [4:0] o_removed;
  logic o_last;

  logic accept, out_free, advance, step_done;
  logic h_match, h_exp, h_sel, is_list, kill;
  logic load;
  logic [1:0] l_status;
  rec_t l_rec;
  logic [4:0] l_removed;
  logic l_last;

  assign new_rec.valid    = 1'b1;
  assign new_rec.code     = req.code;
  assign new_rec.price    = req.price;
  assign new_rec.quantity = req.quantity;
  assign new_rec.expiry   = '{req.date_year, req.date_month, req.date_day};

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !ov || res.ready;
  assign step_done = (step == CW'(TABLE_DEPTH - 1));

  assign is_list = (rq == REQ_LIST_OK) || (rq == REQ_LIST_EXP);
  assign h_match = cell_q[0].valid && (cell_q[0].code == rq_code);
  assign h_exp   = cell_q[0].valid && (cell_q[0].expiry <= rq_date);
  assign h_sel   = cell_q[0].valid && (h_exp == (rq == REQ_LIST_EXP));
  assign kill    = ((rq == REQ_DEL_CODE) && h_match && !found) ||
                   ((rq == REQ_DEL_EXP) && h_exp);
  assign advance = !(is_list && h_sel && found && !out_free);

  always_comb begin
    wrap = cell_q[0];
    if (kill) wrap.valid = 1'b0;
    tail_in = wrap;
    if (state == S_CMP) tail_in.valid = 1'b0;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rec_t lft, rgt;
      logic gl, hl;
      if (g == 0) begin : g_head
        assign lft = '0;
        assign gl  = 1'b0;
        assign hl  = 1'b0;
      end else begin : g_body
        assign lft = cell_q[g-1];
        assign gl  = gt[g-1];
        assign hl  = hole[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : g_tail
        assign rgt = tail_in;
      end else begin : g_mid
        assign rgt = cell_q[g+1];
      end
      srt_cell u_cell (
        .clk(clk), .rst(rst), .op(op), .left(lft), .right(rgt), .new_rec(new_rec),
        .gt_left(gl), .hole_left(hl), .rec(cell_q[g]), .gt(gt[g]), .hole(hole[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    op         = CELL_HOLD;
    load       = 1'b0;
    l_status   = ST_OK;
    l_rec      = '0;
    l_removed  = '0;
    l_last     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_INSERT) begin
            if (fill != CW'(TABLE_DEPTH)) op = CELL_INS;
            state_next = S_FIN;
          end else if (req.req_type <= REQ_LIST_EXP) begin
            state_next = S_ROT;
          end
        end
      end
      S_ROT: begin
        if (advance) begin
          op = CELL_ROT;
          if (is_list && h_sel && found) begin
            load  = 1'b1;
            l_rec = held;
          end
          if (step_done) state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load   = 1'b1;
          l_last = 1'b1;
          case (rq)
            REQ_INSERT: l_status = ins_status;
            REQ_FIND: begin
              l_status = found ? ST_OK : ST_NOTFOUND;
              l_rec    = found ? held : '0;
            end
            REQ_DEL_CODE: begin
              l_status  = found ? ST_OK : ST_NOTFOUND;
              l_removed = {4'd0, found};
            end
            REQ_DEL_EXP: l_removed = removed;
            default: begin
              l_status = found ? ST_OK : ST_NOTFOUND;
              l_rec    = found ? held : '0;
            end
          endcase
          if (rq == REQ_DEL_CODE || rq == REQ_DEL_EXP) state_next = S_CMP;
          else state_next = S_IDLE;
        end
      end
      S_CMP: begin
        op = CELL_CMP;
        if (step_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      ov    <= 1'b0;
      step  <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (load) ov <= 1'b1;
      else if (res.ready) ov <= 1'b0;
      if (op == CELL_INS) fill <= fill + CW'(1);
      if (op == CELL_ROT && kill) fill <= fill - CW'(1);
      if (state != state_next) step <= '0;
      else if (op == CELL_ROT || op == CELL_CMP) step <= step + CW'(1);
      if (accept) begin
        found <= 1'b0;
      end else if (op == CELL_ROT) begin
        if ((rq == REQ_FIND || rq == REQ_DEL_CODE) && h_match) found <= 1'b1;
        if (is_list && h_sel) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rq         <= req.req_type;
      rq_code    <= req.code;
      rq_date    <= new_rec.expiry;
      removed    <= '0;
      ins_status <= (fill == CW'(TABLE_DEPTH)) ? ST_FULL : ST_OK;
    end else if (op == CELL_ROT) begin
      if (rq == REQ_DEL_EXP && h_exp) removed <= removed + 5'd1;
      if (rq == REQ_FIND && h_match && !found) held <= cell_q[0];
      if (is_list && h_sel) held <= cell_q[0];
    end
    if (load) begin
      o_status  <= l_status;
      o_rec     <= l_rec;
      o_removed <= l_removed;
      o_last    <= l_last;
    end
  end

  assign res.valid         = ov;
  assign res.status        = o_status;
  assign res.rec_code      = o_rec.code;
  assign res.rec_price     = o_rec.price;
  assign res.rec_quantity  = o_rec.quantity;
  assign res.rec_day       = o_rec.expiry.day;
  assign res.rec_month     = o_rec.expiry.month;
  assign res.rec_year      = o_rec.expiry.year;
  assign res.removed_count = o_removed;
  assign res.last          = o_last;
endmodule

// ===== sim/srt_table_checker.sv =====
// ----------------------------------------------------------------------------
// srt_table_checker: result predictor and comparator for the record table
// Watches the request and result channels. It keeps its own copy of the
// price-ordered table, works out the result words of every accepted request
// and compares each accepted result word with the oldest expected one.
// ----------------------------------------------------------------------------
module srt_table_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  srt_req_if   req,
  srt_res_if   res,
  output int   fail_count,
  output int   pending_count
);
  import srt_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] code;
    logic [23:0]        price;
    logic [15:0]        quantity;
    date_t              expiry;
    logic [4:0]         removed;
    logic               last;
  } result_word_t;

  typedef struct packed {
    logic signed [31:0] code;
    logic [23:0]        price;
    logic [15:0]        quantity;
    date_t              expiry;
  } entry_t;

  entry_t       table_q[$];
  result_word_t expected_q[$];

  function automatic result_word_t blank_word(logic [1:0] status, logic [4:0] removed);
    result_word_t w;
    w = '0;
    w.status  = status;
    w.removed = removed;
    w.last    = 1'b1;
    return w;
  endfunction

  function automatic result_word_t entry_word(entry_t e);
    result_word_t w;
    w = '0;
    w.status   = ST_OK;
    w.code     = e.code;
    w.price    = e.price;
    w.quantity = e.quantity;
    w.expiry   = e.expiry;
    return w;
  endfunction

  task automatic predict_request();
    entry_t       e;
    date_t        ref_date;
    int           pos;
    int           n;
    logic [4:0]   removed;
    logic         want_expired;
    result_word_t w;
    begin
      e.code = req.code;
      e.price = req.price;
      e.quantity = req.quantity;
      ref_date = {req.date_year, req.date_month, req.date_day};
      e.expiry = ref_date;
      case (req.req_type)
        REQ_INSERT: begin
          if (table_q.size() >= TABLE_DEPTH) begin
            expected_q.push_back(blank_word(ST_FULL, 5'd0));
          end else begin
            pos = table_q.size();
            for (int i = 0; i < table_q.size(); i++) begin
              if (table_q[i].price > e.price) begin
                pos = i;
                break;
              end
            end
            table_q.insert(pos, e);
            expected_q.push_back(blank_word(ST_OK, 5'd0));
          end
        end
        REQ_FIND, REQ_DEL_CODE: begin
          pos = -1;
          for (int i = 0; i < table_q.size(); i++) begin
            if (table_q[i].code == e.code) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) begin
            expected_q.push_back(blank_word(ST_NOTFOUND, 5'd0));
          end else if (req.req_type == REQ_FIND) begin
            w = entry_word(table_q[pos]);
            w.last = 1'b1;
            expected_q.push_back(w);
          end else begin
            table_q.delete(pos);
            expected_q.push_back(blank_word(ST_OK, 5'd1));
          end
        end
        REQ_DEL_EXP: begin
          removed = '0;
          for (int i = table_q.size() - 1; i >= 0; i--) begin
            if (table_q[i].expiry <= ref_date) begin
              table_q.delete(i);
              removed++;
            end
          end
          expected_q.push_back(blank_word(ST_OK, removed));
        end
        REQ_LIST_OK, REQ_LIST_EXP: begin
          want_expired = (req.req_type == REQ_LIST_EXP);
          n = 0;
          foreach (table_q[i]) begin
            if ((table_q[i].expiry <= ref_date) == want_expired) begin
              expected_q.push_back(entry_word(table_q[i]));
              n++;
            end
          end
          if (n == 0) expected_q.push_back(blank_word(ST_NOTFOUND, 5'd0));
          else expected_q[$].last = 1'b1;
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_word_t exp_w;
    begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_w = expected_q.pop_front();
        compare_field("status", exp_w.status, res.status);
        compare_field("rec_code", exp_w.code, res.rec_code);
        compare_field("rec_price", exp_w.price, res.rec_price);
        compare_field("rec_quantity", exp_w.quantity, res.rec_quantity);
        compare_field("rec_day", exp_w.expiry.day, res.rec_day);
        compare_field("rec_month", exp_w.expiry.month, res.rec_month);
        compare_field("rec_year", exp_w.expiry.year, res.rec_year);
        compare_field("removed_count", exp_w.removed, res.removed_count);
        compare_field("last", exp_w.last, res.last);
      end
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      table_q.delete();
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) check_result();
      if (req.valid && req.ready) predict_request();
    end
  end

  assign pending_count = expected_q.size();

endmodule

// ===== sim/tb_sorted_record_table_with_expiry_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_record_table_with_expiry_core: record table testbench
// Drives directed and random requests with random gaps and result stalls,
// including a long result hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_sorted_record_table_with_expiry_core;
  import srt_pkg::*;

  localparam int DEPTH = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;
  logic signed [31:0] used_codes[$];

  srt_req_if req ();
  srt_res_if res ();

  sorted_record_table_with_expiry_core #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  srt_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_INSERT;
    req.code = '0;
    req.price = '0;
    req.quantity = '0;
    req.date_day = 5'd1;
    req.date_month = 4'd1;
    req.date_year = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic [2:0] kind, logic signed [31:0] code, logic [23:0] price,
                           logic [15:0] qty, logic [4:0] d, logic [3:0] m,
                           logic [13:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.code <= code;
    req.price <= price;
    req.quantity <= qty;
    req.date_day <= d;
    req.date_month <= m;
    req.date_year <= y;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    logic [2:0]         kind;
    logic signed [31:0] code;
    logic [23:0]        price;
    logic [4:0]         d;
    logic [3:0]         m;
    logic [13:0]        y;
    int                 pick;
    begin
      pick = $urandom_range(99);
      if (pick < 40) kind = REQ_INSERT;
      else if (pick < 52) kind = REQ_FIND;
      else if (pick < 64) kind = REQ_DEL_CODE;
      else if (pick < 72) kind = REQ_DEL_EXP;
      else if (pick < 84) kind = REQ_LIST_OK;
      else if (pick < 96) kind = REQ_LIST_EXP;
      else kind = 3'($urandom_range(7, 6));
      if (used_codes.size() > 0 && $urandom_range(3) != 0 && kind != REQ_INSERT)
        code = used_codes[$urandom_range(used_codes.size() - 1)];
      else if ($urandom_range(1)) code = $signed(32'($urandom_range(7)));
      else code = $signed(32'($urandom));
      if (kind == REQ_INSERT) used_codes.push_back(code);
      if (used_codes.size() > 40) void'(used_codes.pop_front());
      price = $urandom_range(1) ? 24'($urandom_range(8)) : 24'($urandom);
      if ($urandom_range(7) == 0) begin
        d = 5'($urandom);
        m = 4'($urandom);
        y = 14'($urandom);
      end else begin
        d = 5'($urandom_range(31, 1));
        m = 4'($urandom_range(12, 1));
        y = 14'($urandom_range(2026, 2022));
      end
      send_word(kind, code, price, 16'($urandom), d, m, y);
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty-table cases, extremes, ties and a full table.
    send_word(REQ_FIND, 32'sd5, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_LIST_OK, '0, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_DEL_CODE, 32'sd5, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_INSERT, 32'h7FFF_FFFF, 24'hFFFFFF, 16'hFFFF, 5'd31, 4'd12, 14'd9999);
    send_word(REQ_INSERT, 32'h8000_0000, 24'd0, 16'd0, 5'd1, 4'd1, 14'd0);
    send_word(REQ_INSERT, 32'sd7, 24'd100, 16'd3, 5'd31, 4'd15, 14'h3FFF);
    send_word(REQ_INSERT, 32'sd8, 24'd100, 16'd4, 5'd0, 4'd0, 14'd2024);
    send_word(REQ_INSERT, 32'sd7, 24'd50, 16'd5, 5'd15, 4'd6, 14'd2024);
    send_word(REQ_FIND, 32'sd7, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_LIST_OK, '0, '0, '0, 5'd15, 4'd6, 14'd2024);
    send_word(REQ_LIST_EXP, '0, '0, '0, 5'd15, 4'd6, 14'd2024);
    send_word(3'd6, 32'sd7, '0, '0, 5'd1, 4'd1, '0);
    send_word(3'd7, 32'sd7, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_DEL_CODE, 32'sd7, '0, '0, 5'd1, 4'd1, '0);
    send_word(REQ_DEL_EXP, '0, '0, '0, 5'd15, 4'd6, 14'd2024);
    send_word(REQ_DEL_EXP, '0, '0, '0, 5'd1, 4'd1, 14'd0);
    for (int i = 0; i < DEPTH + 1; i++)
      send_word(REQ_INSERT, $signed(32'(i)), 24'($urandom_range(20)), 16'($urandom),
                5'd1, 4'd1, 14'd2025);
    send_word(REQ_LIST_OK, '0, '0, '0, 5'd1, 4'd1, 14'd0);
    send_word(REQ_DEL_EXP, '0, '0, '0, 5'd31, 4'd15, 14'h3FFF);
    send_word(REQ_LIST_EXP, '0, '0, '0, 5'd31, 4'd15, 14'h3FFF);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 57; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 57; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      if (phase == 2) hold_cycles = 400;
      repeat (110) send_random_word();
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
